FILE: hdl/planar_chain_forward_kinematics_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the planar chain kinematics block.
// ----------------------------------------------------------------------------
`ifndef PLANAR_CHAIN_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define PLANAR_CHAIN_FORWARD_KINEMATICS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PCFK_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcfk assertion failed");
`define PCFK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcfk assertion failed");
`else
`define PCFK_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PCFK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/pcfk_pkg.sv
// ----------------------------------------------------------------------------
// pcfk_pkg
// Types and constants of the planar chain forward kinematics block.
// ----------------------------------------------------------------------------
package pcfk_pkg;

    localparam int NUM_LINKS = 4;
    localparam int NUM_ITER  = 16;
    localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [32:0] z;
        logic               flip;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LINKS-1:0] lane;
        logic signed [15:0]    head_x;
        logic signed [15:0]    head_y;
    } t_beat;

    function automatic logic signed [32:0] atan_step(input int idx);
        logic signed [32:0] v;
        case (idx)
            0: v = 33'sd536870912;
            1: v = 33'sd316933406;
            2: v = 33'sd167458907;
            3: v = 33'sd85004756;
            4: v = 33'sd42667331;
            5: v = 33'sd21354465;
            6: v = 33'sd10679838;
            7: v = 33'sd5340245;
            8: v = 33'sd2670163;
            9: v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41721;
            15: v = 33'sd20860;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/planar_chain_forward_kinematics_top.sv
// ----------------------------------------------------------------------------
// planar_chain_forward_kinematics_top
// Forward kinematics of a four-link planar chain with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// One pose beat is taken every clock cycle while the output is not stalled.
// A register holds the formed and folded link angles, a row of 16 CORDIC
// cells follows, then a register scales by the link length, one sums the
// points and one saturates into the output register. When the output is
// stalled the whole pipeline holds, and the input is stalled with it.
module planar_chain_forward_kinematics_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_head_x,
    input  logic signed [15:0] i_head_y,
    input  logic signed [15:0] i_head_heading,
    input  logic signed [15:0] i_joint_one_angle,
    input  logic signed [15:0] i_joint_two_angle,
    input  logic signed [15:0] i_joint_three_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_first_joint_x,
    output logic signed [15:0] o_first_joint_y,
    output logic signed [15:0] o_second_joint_x,
    output logic signed [15:0] o_second_joint_y,
    output logic signed [15:0] o_third_joint_x,
    output logic signed [15:0] o_third_joint_y,
    output logic signed [15:0] o_tail_x,
    output logic signed [15:0] o_tail_y
);

    `include "planar_chain_forward_kinematics_top_macros.svh"

    localparam int NL = pcfk_pkg::NUM_LINKS;
    localparam int NI = pcfk_pkg::NUM_ITER;

    logic [14:0] r_link_length;
    logic        w_adv;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_length <= 15'd1024;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_link_length <= pwdata[14:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : {17'd0, r_link_length};

    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // Angle formation and quadrant fold.
    logic [15:0]     w_ang [NL];
    pcfk_pkg::t_beat n_s0;
    pcfk_pkg::t_beat r_s0;
    logic            r_s0_valid;

    always_comb begin
        logic        fl;
        logic [15:0] a;
        w_ang[0] = i_head_heading;
        w_ang[1] = w_ang[0] + i_joint_one_angle;
        w_ang[2] = w_ang[1] + i_joint_two_angle;
        w_ang[3] = w_ang[2] + i_joint_three_angle;
        n_s0.head_x = i_head_x;
        n_s0.head_y = i_head_y;
        for (int k = 0; k < NL; k++) begin
            fl = w_ang[k][15] ^ w_ang[k][14];
            a  = w_ang[k] ^ {fl, 15'd0};
            n_s0.lane[k].x    = pcfk_pkg::CORDIC_START;
            n_s0.lane[k].y    = 33'sd0;
            n_s0.lane[k].z    = $signed({a[15], a, 16'd0});
            n_s0.lane[k].flip = fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= n_s0;
        end
    end

    // Row of CORDIC cells.
    pcfk_pkg::t_beat w_beat  [NI+1];
    logic            w_valid [NI+1];

    assign w_beat[0]  = r_s0;
    assign w_valid[0] = r_s0_valid;

    for (genvar g = 0; g < NI; g++) begin : g_cell
        pcfk_cell #(
            .ITER (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    // Link offsets: sign restored first, then length times cosine and sine,
    // rounded. Rounding a negated product differs on ties, so order matters.
    logic signed [18:0] n_off_x [NL];
    logic signed [18:0] n_off_y [NL];
    logic signed [18:0] r_off_x [NL];
    logic signed [18:0] r_off_y [NL];
    logic signed [15:0] r_mul_hx;
    logic signed [15:0] r_mul_hy;
    logic               r_mul_valid;

    always_comb begin
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [48:0] px;
        logic signed [48:0] py;
        for (int k = 0; k < NL; k++) begin
            if (w_beat[NI].lane[k].flip) begin
                cx = -w_beat[NI].lane[k].x;
                cy = -w_beat[NI].lane[k].y;
            end else begin
                cx = w_beat[NI].lane[k].x;
                cy = w_beat[NI].lane[k].y;
            end
            px = $signed({1'b0, r_link_length}) * cx + 49'sd536870912;
            py = $signed({1'b0, r_link_length}) * cy + 49'sd536870912;
            n_off_x[k] = px[48:30];
            n_off_y[k] = py[48:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (w_adv) begin
            r_mul_valid <= w_valid[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_off_x  <= n_off_x;
            r_off_y  <= n_off_y;
            r_mul_hx <= w_beat[NI].head_x;
            r_mul_hy <= w_beat[NI].head_y;
        end
    end

    // Points along the chain at full precision.
    logic signed [19:0] n_pt_x [NL];
    logic signed [19:0] n_pt_y [NL];
    logic signed [19:0] r_pt_x [NL];
    logic signed [19:0] r_pt_y [NL];
    logic               r_sum_valid;

    always_comb begin
        n_pt_x[0] = 20'(r_mul_hx) - 20'(r_off_x[0]);
        n_pt_y[0] = 20'(r_mul_hy) - 20'(r_off_y[0]);
        for (int k = 1; k < NL; k++) begin
            n_pt_x[k] = n_pt_x[k-1] - 20'(r_off_x[k]);
            n_pt_y[k] = n_pt_y[k-1] - 20'(r_off_y[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (w_adv) begin
            r_sum_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pt_x <= n_pt_x;
            r_pt_y <= n_pt_y;
        end
    end

    // Saturation into the output register.
    logic signed [15:0] n_sat_x [NL];
    logic signed [15:0] n_sat_y [NL];
    logic signed [15:0] r_sat_x [NL];
    logic signed [15:0] r_sat_y [NL];
    logic               r_out_valid;

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            if (r_pt_x[k] > 20'sd32767) begin
                n_sat_x[k] = 16'sh7fff;
            end else if (r_pt_x[k] < -20'sd32768) begin
                n_sat_x[k] = 16'sh8000;
            end else begin
                n_sat_x[k] = r_pt_x[k][15:0];
            end
            if (r_pt_y[k] > 20'sd32767) begin
                n_sat_y[k] = 16'sh7fff;
            end else if (r_pt_y[k] < -20'sd32768) begin
                n_sat_y[k] = 16'sh8000;
            end else begin
                n_sat_y[k] = r_pt_y[k][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sat_x <= n_sat_x;
            r_sat_y <= n_sat_y;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_joint_x  = r_sat_x[0];
    assign o_first_joint_y  = r_sat_y[0];
    assign o_second_joint_x = r_sat_x[1];
    assign o_second_joint_y = r_sat_y[1];
    assign o_third_joint_x  = r_sat_x[2];
    assign o_third_joint_y  = r_sat_y[2];
    assign o_tail_x         = r_sat_x[3];
    assign o_tail_y         = r_sat_y[3];

    `PCFK_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_s0_valid)
    `PCFK_ASSERT_NEXT(a_row_to_scale, i_clk, i_rst_n, w_adv && w_valid[NI], r_mul_valid)
    `PCFK_ASSERT_NEXT(a_sum_to_out, i_clk, i_rst_n, w_adv && r_sum_valid, o_out_valid)

endmodule

FILE: hdl/pcfk_cell.sv
// ----------------------------------------------------------------------------
// pcfk_cell
// One CORDIC rotation step for all four links, registered.
// ----------------------------------------------------------------------------
module pcfk_cell #(
    parameter int ITER = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pcfk_pkg::t_beat i_beat,
    output logic            o_valid,
    output pcfk_pkg::t_beat o_beat
);

    localparam logic signed [32:0] ATAN = pcfk_pkg::atan_step(ITER);

    pcfk_pkg::t_beat n_beat;
    pcfk_pkg::t_beat r_beat;
    logic            r_valid;

    always_comb begin
        n_beat = i_beat;
        for (int k = 0; k < pcfk_pkg::NUM_LINKS; k++) begin
            if (!i_beat.lane[k].z[32]) begin
                n_beat.lane[k].x = i_beat.lane[k].x - (i_beat.lane[k].y >>> ITER);
                n_beat.lane[k].y = i_beat.lane[k].y + (i_beat.lane[k].x >>> ITER);
                n_beat.lane[k].z = i_beat.lane[k].z - ATAN;
            end else begin
                n_beat.lane[k].x = i_beat.lane[k].x + (i_beat.lane[k].y >>> ITER);
                n_beat.lane[k].y = i_beat.lane[k].y - (i_beat.lane[k].x >>> ITER);
                n_beat.lane[k].z = i_beat.lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Planar chain forward kinematics testbench
// Drives pose beats with random gaps and output stalls, predicts every joint
// and tail point with a fixed-point CORDIC model, and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PIPE_LATENCY   = 20;
    localparam logic [2:0] ADDR_LINK_LENGTH = 3'd0;

    typedef struct {
        logic signed [15:0] hx, hy, hd, j1, j2, j3;
    } t_pose;

    typedef struct {
        logic signed [15:0] p[8];
    } t_chain_points;

    typedef struct {
        t_pose         pose;
        logic          has_golden;
        t_chain_points golden;
    } t_pose_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_head_x, i_head_y, i_head_heading;
    logic signed [15:0] i_joint_one_angle, i_joint_two_angle, i_joint_three_angle;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_first_joint_x, o_first_joint_y;
    logic signed [15:0] o_second_joint_x, o_second_joint_y;
    logic signed [15:0] o_third_joint_x, o_third_joint_y;
    logic signed [15:0] o_tail_x, o_tail_y;

    planar_chain_forward_kinematics_top DUT (.*);

    t_chain_points expected_points[$];
    logic [14:0]   link_len_model;
    int            mismatch_count;
    int            result_count;
    int            pose_count;
    int            idle_cycles;
    int            row_idx;
    t_pose_row     pose_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Arithmetic shift with floor, matching the hardware shifter.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void cordic_cos_sin(logic [15:0] ang, output longint c,
                                           output longint s);
        longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41721, 20860};
        logic [15:0] a;
        bit          flip;
        longint      x, y, z, xs, ys;
        a    = ang;
        flip = (a[15:14] == 2'd1) || (a[15:14] == 2'd2);
        if (flip) a[15] = ~a[15];
        x = 652032874;
        y = 0;
        z = longint'($signed(a)) * 65536;
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_chain_points predict_chain(t_pose p, logic [14:0] len);
        t_chain_points r;
        longint px, py, c, s;
        logic [15:0] ang;
        logic [15:0] rel[4];
        rel = '{p.hd, p.j1, p.j2, p.j3};
        px  = p.hx;
        py  = p.hy;
        ang = 16'd0;
        for (int k = 0; k < 4; k++) begin
            ang = ang + rel[k];
            cordic_cos_sin(ang, c, s);
            px -= floor_shift(longint'(len) * c + (64'sd1 <<< 29), 30);
            py -= floor_shift(longint'(len) * s + (64'sd1 <<< 29), 30);
            r.p[2*k]   = clamp16(px);
            r.p[2*k+1] = clamp16(py);
        end
        return r;
    endfunction

    task automatic write_link_length(logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LINK_LENGTH;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        link_len_model = value[14:0];
    endtask

    // Valid stays high after an accepted beat; the next call or the caller
    // drops it, so back-to-back beats never see a dead cycle.
    task automatic send_pose(t_pose p, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_head_x            <= p.hx;
        i_head_y            <= p.hy;
        i_head_heading      <= p.hd;
        i_joint_one_angle   <= p.j1;
        i_joint_two_angle   <= p.j2;
        i_joint_three_angle <= p.j3;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_points.insert(expected_points.size(), predict_chain(p, link_len_model));
        pose_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic t_pose random_pose();
        t_pose p;
        case ($urandom_range(0, 5))
            0: begin
                // Heads near the rails so the chain saturates.
                p.hx = $urandom_range(0, 1) ? 16'(16'sh7f00 + $urandom_range(0, 255))
                                            : 16'(16'sh8000 + $urandom_range(0, 255));
                p.hy = $urandom_range(0, 1) ? 16'(16'sh7f00 + $urandom_range(0, 255))
                                            : 16'(16'sh8000 + $urandom_range(0, 255));
            end
            default: begin
                p.hx = 16'($urandom);
                p.hy = 16'($urandom);
            end
        endcase
        p.hd = 16'($urandom);
        p.j1 = 16'($urandom);
        p.j2 = 16'($urandom);
        p.j3 = 16'($urandom);
        // Angles on quadrant boundaries exercise the fold.
        if ($urandom_range(0, 7) == 0) p.hd = 16'($urandom_range(0, 3) << 14);
        if ($urandom_range(0, 7) == 0) p.j1 = 16'($urandom_range(0, 3) << 14);
        return p;
    endfunction

    function automatic t_pose_row row(int hx, int hy, int hd, int j1, int j2, int j3);
        t_pose_row r;
        r.pose = '{16'(hx), 16'(hy), 16'(hd), 16'(j1), 16'(j2), 16'(j3)};
        r.has_golden = 1'b0;
        return r;
    endfunction

    task automatic add_row(int hx, int hy, int hd, int j1, int j2, int j3);
        pose_rows.insert(pose_rows.size(), row(hx, hy, hd, j1, j2, j3));
    endtask

    // Receiver: random stalls, compare every accepted beat.
    initial begin
        t_chain_points want, got;
        int hold;
        i_out_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 4) == 0) hold = 0;
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.p = '{o_first_joint_x, o_first_joint_y, o_second_joint_x,
                      o_second_joint_y, o_third_joint_x, o_third_joint_y,
                      o_tail_x, o_tail_y};
            result_count++;
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected result beat");
            end else begin
                want = expected_points.pop_front();
                for (int f = 0; f < 8; f++) begin
                    if (got.p[f] !== want.p[f]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Result %0d field %0d: expected %0d, got %0d",
                                     result_count, f, want.p[f], got.p[f]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles where nothing is accepted.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_pose       p;
        int          gap;
        logic [31:0] lengths[5];
        lengths = '{32'd0, 32'd32767, 32'hffff_8400, 32'd4096, 32'd1};
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0;
        i_head_x = '0; i_head_y = '0; i_head_heading = '0;
        i_joint_one_angle = '0; i_joint_two_angle = '0; i_joint_three_angle = '0;
        mismatch_count = 0; result_count = 0; pose_count = 0; idle_cycles = 0;
        link_len_model = 15'd1024;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset length of 0.25 m.
        add_row(0, 0, 0, 0, 0, 0);
        pose_rows[0].has_golden = 1'b1;
        pose_rows[0].golden.p = '{-16'sd1024, 16'sd0, -16'sd2048, 16'sd0,
                                  -16'sd3072, 16'sd0, -16'sd4096, 16'sd0};
        add_row(32767, 32767, 0, 0, 0, 0);
        add_row(-32768, -32768, 32768, 0, 0, 0);
        add_row(-32768, 0, 32768, 0, 0, 0);
        pose_rows[3].has_golden = 1'b1;
        pose_rows[3].golden.p = '{-16'sd31744, 16'sd0, -16'sd30720, 16'sd0,
                                  -16'sd29696, 16'sd0, -16'sd28672, 16'sd0};
        add_row(32767, 0, 0, 0, 0, 0);
        pose_rows[4].has_golden = 1'b1;
        pose_rows[4].golden.p = '{16'sd31743, 16'sd0, 16'sd30719, 16'sd0,
                                  16'sd29695, 16'sd0, 16'sd28671, 16'sd0};
        add_row(0, 0, 16384, 16384, 16384, 16384);
        add_row(0, 0, -16384, -16384, -16384, -16384);
        add_row(0, 0, 16383, 1, 32767, -32768);
        add_row(0, 0, 49151, 49152, 32768, 8192);
        add_row(100, -100, 32767, 32767, 32767, 32767);
        add_row(0, 32767, 16384, 0, 0, 0);
        add_row(0, -32768, -16384, 0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1);
        add_row(21845, -21846, 21845, -21846, 21845, -21846);

        for (row_idx = 0; row_idx < pose_rows.size(); row_idx++) begin
            send_pose(pose_rows[row_idx].pose, $urandom_range(0, 2));
            if (pose_rows[row_idx].has_golden)
                expected_points[$] = pose_rows[row_idx].golden;
        end
        drain_results();

        // Random phases over several link lengths, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 5) write_link_length(lengths[ph]);
            else write_link_length($urandom_range(0, 32767));
            for (int n = 0; n < 90; n++) begin
                p = random_pose();
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
                if (n == 45) begin
                    // Let the pipeline empty completely before resuming.
                    i_in_valid <= 1'b0;
                    while (expected_points.size() != 0) @(posedge i_clk);
                end
                send_pose(p, gap);
            end
            drain_results();
        end

        $display("Sent %0d pose beats over 7 link lengths; checked %0d result beats.",
                 pose_count, result_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
